### hdl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared widths, constants, register indexes and types of the letterbox
// point mapper.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // coordinate and register widths
  localparam int CW      = 14;
  localparam int PW      = 8;
  localparam int PCTW    = 7;
  localparam int PROD_W  = 2 * CW;
  localparam int PTW     = 16;

  // scale limits in percent
  localparam logic [PW-1:0] PCT_MIN  = PW'(10);
  localparam logic [PW-1:0] PCT_MAX  = PW'(200);
  localparam logic [PW-1:0] PCT_FULL = PW'(100);

  // register indexes
  localparam logic [2:0] REG_DESIGN_W = 3'd0;
  localparam logic [2:0] REG_DESIGN_H = 3'd1;
  localparam logic [2:0] REG_TARGET_W = 3'd2;
  localparam logic [2:0] REG_TARGET_H = 3'd3;
  localparam logic [2:0] REG_SCALE    = 3'd4;

  // reset values
  localparam logic [CW-1:0] RST_DESIGN_W = CW'(640);
  localparam logic [CW-1:0] RST_DESIGN_H = CW'(480);
  localparam logic [CW-1:0] RST_TARGET_W = CW'(640);
  localparam logic [CW-1:0] RST_TARGET_H = CW'(480);
  localparam logic [PW-1:0] RST_SCALE    = PW'(100);

  // presentation rectangle
  typedef struct packed {
    logic          nonempty;
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] width;
    logic [CW-1:0] height;
  } lpm_rect_t;

  // one restoring division step: acc holds remainder over remaining dividend
  function automatic logic [PROD_W-1:0] lpm_div_step(input logic [PROD_W-1:0] acc,
                                                     input logic [CW-1:0] den);
    logic [PROD_W:0] sh;
    logic [CW:0]     top;
    logic            ge;
    logic [CW:0]     newtop;
    sh     = {acc, 1'b0};
    top    = sh[PROD_W:CW];
    ge     = (top >= {1'b0, den});
    newtop = ge ? (top - {1'b0, den}) : top;
    return {newtop[CW-1:0], sh[CW-1:1], ge};
  endfunction

endpackage

### hdl/lpm_rect_calc.sv
// ----------------------------------------------------------------------------
// lpm_rect_calc
// Sequencer that recomputes the presentation rectangle after reset and after
// every register write: a reciprocal multiply for the limiting axis and a
// bit-serial divider for the other axis.
// ----------------------------------------------------------------------------
module lpm_rect_calc (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr,
  input  logic [lpm_pkg::CW-1:0]  design_w,
  input  logic [lpm_pkg::CW-1:0]  design_h,
  input  logic [lpm_pkg::CW-1:0]  target_w,
  input  logic [lpm_pkg::CW-1:0]  target_h,
  input  logic [lpm_pkg::PW-1:0]  scale,
  output logic                    rect_ready,
  output lpm_pkg::lpm_rect_t      rect
);

  localparam int NW  = 36;   // dividend width
  localparam int DW  = 22;   // divisor width
  localparam int CNW = 6;

  // divide by 200 as divide by 8, then multiply by 2^24/25 rounded up
  localparam int PNW = 19;
  localparam int RCW = 20;
  localparam int PQW = PNW + RCW;
  localparam int RSH = 24;
  localparam logic [RCW-1:0] RECIP_25 = RCW'(671089);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_DIV1 = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  logic                         dirty_r, dirty_nxt;
  logic [lpm_pkg::PROD_W-1:0]   prod_a_r, prod_b_r;
  logic                         lim_w_r;
  logic                         empty_r;
  logic [NW-1:0]                num_r, num2_r;
  logic [DW-1:0]                den_r, den2_r;
  logic [DW-1:0]                rem_r;
  logic [CNW-1:0]               cnt_r;
  logic [NW-1:0]                q1_r;
  lpm_pkg::lpm_rect_t           rect_r;

  // clamped percent
  logic [lpm_pkg::PCTW-1:0]     pct;
  always_comb begin
    if (scale < lpm_pkg::PCT_MIN) begin
      pct = lpm_pkg::PCTW'(lpm_pkg::PCT_MIN);
    end else if (scale > lpm_pkg::PCT_FULL) begin
      pct = lpm_pkg::PCTW'(lpm_pkg::PCT_FULL);
    end else begin
      pct = scale[lpm_pkg::PCTW-1:0];
    end
  end

  // limiting axis size: (2*t*p + 100) / 200
  logic [PQW-1:0] pct_prod;
  always_comb begin
    pct_prod = PQW'(num_r[PNW+2:3]) * PQW'(RECIP_25);
  end

  // one divider step
  logic [DW:0] trial;
  logic        ge;
  always_comb begin
    trial = {rem_r, num_r[NW-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  // operands of the two divisions
  logic                       lim;
  logic [lpm_pkg::CW-1:0]     t_lim, d_lim;
  logic [lpm_pkg::PROD_W-1:0] p_lim;
  always_comb begin
    lim   = (prod_a_r <= prod_b_r);
    t_lim = lim ? target_w : target_h;
    d_lim = lim ? design_w : design_h;
    p_lim = lim ? prod_a_r : prod_b_r;
  end

  // final clamp and centering
  logic [NW-1:0]          r_lim_q, r_oth_q;
  logic [lpm_pkg::CW-1:0] t_oth, r_lim, r_oth, rw, rh;
  always_comb begin
    r_lim_q = q1_r;
    r_oth_q = num_r;
    t_oth   = lim_w_r ? target_h : target_w;
    if (r_lim_q == '0) begin
      r_lim = lpm_pkg::CW'(1);
    end else if (r_lim_q > NW'(t_lim)) begin
      r_lim = t_lim;
    end else begin
      r_lim = r_lim_q[lpm_pkg::CW-1:0];
    end
    if (r_oth_q == '0) begin
      r_oth = lpm_pkg::CW'(1);
    end else if (r_oth_q > NW'(t_oth)) begin
      r_oth = t_oth;
    end else begin
      r_oth = r_oth_q[lpm_pkg::CW-1:0];
    end
    rw = lim_w_r ? r_lim : r_oth;
    rh = lim_w_r ? r_oth : r_lim;
  end

  // sequencer control
  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r | cfg_wr;
    unique case (state_r)
      ST_IDLE: begin
        if (dirty_r) begin
          state_nxt = ST_MUL;
          dirty_nxt = cfg_wr;
        end
      end
      ST_MUL:  state_nxt = ST_SEL;
      ST_SEL:  state_nxt = empty_r ? ST_FIN : ST_DIV1;
      ST_DIV1: state_nxt = ST_DIV2;
      ST_DIV2: begin
        if (cnt_r == CNW'(NW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dirty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL: begin
        prod_a_r <= lpm_pkg::PROD_W'(target_w) * lpm_pkg::PROD_W'(design_h);
        prod_b_r <= lpm_pkg::PROD_W'(target_h) * lpm_pkg::PROD_W'(design_w);
        empty_r  <= (target_w == '0) || (target_h == '0) ||
                    (design_w == '0) || (design_h == '0);
      end
      ST_SEL: begin
        lim_w_r <= lim;
        num_r   <= NW'({t_lim, 1'b0}) * NW'(pct) + NW'(lpm_pkg::PCT_FULL);
        num2_r  <= NW'({p_lim, 1'b0}) * NW'(pct) +
                   NW'(d_lim) * NW'(lpm_pkg::PCT_FULL);
        den2_r  <= DW'(d_lim) * DW'(lpm_pkg::PCT_MAX);
        rem_r   <= '0;
        cnt_r   <= '0;
      end
      ST_DIV1: begin
        q1_r  <= NW'(pct_prod[PQW-1:RSH]);
        num_r <= num2_r;
        den_r <= den2_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV2: begin
        num_r <= {num_r[NW-2:0], ge};
        rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        cnt_r <= cnt_r + CNW'(1);
      end
      ST_FIN: begin
        if (empty_r) begin
          rect_r <= '0;
        end else begin
          rect_r.nonempty <= 1'b1;
          rect_r.width    <= rw;
          rect_r.height   <= rh;
          rect_r.left     <= (target_w - rw) >> 1;
          rect_r.top      <= (target_h - rh) >> 1;
        end
      end
      default: ;
    endcase
  end

  assign rect_ready = (state_r == ST_IDLE) && !dirty_r;
  assign rect       = rect_r;

endmodule

### hdl/lpm_point_pipe.sv
// ----------------------------------------------------------------------------
// lpm_point_pipe
// Point pipeline: rectangle test, multiply by design size, then one
// restoring division step per stage back to design coordinates.
// ----------------------------------------------------------------------------
module lpm_point_pipe (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [lpm_pkg::PTW-1:0]  point_x,
  input  logic [lpm_pkg::PTW-1:0]  point_y,
  input  lpm_pkg::lpm_rect_t       rect,
  input  logic [lpm_pkg::CW-1:0]   design_w,
  input  logic [lpm_pkg::CW-1:0]   design_h,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     inside_res,
  output logic [lpm_pkg::CW-1:0]   design_x,
  output logic [lpm_pkg::CW-1:0]   design_y
);

  localparam int NS = lpm_pkg::CW + 2;   // capture, multiply, CW divide steps
  localparam int OW = lpm_pkg::PTW + 1;

  logic [NS-1:0]                valid_r;
  logic [NS-1:0]                valid_in;
  logic [NS-1:0]                inside_r;
  logic [lpm_pkg::PROD_W-1:0]   acc_x_r [NS];
  logic [lpm_pkg::PROD_W-1:0]   acc_y_r [NS];
  logic [NS-1:0]                load;

  // per-stage load enables, walked back from the output
  always_comb begin
    logic nxt_ready;
    nxt_ready = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      load[i]   = !valid_r[i] || nxt_ready;
      nxt_ready = load[i];
    end
  end

  // rectangle hit test
  logic signed [OW-1:0] ox, oy;
  logic                 hit;
  always_comb begin
    ox  = $signed({point_x[lpm_pkg::PTW-1], point_x}) - $signed(OW'(rect.left));
    oy  = $signed({point_y[lpm_pkg::PTW-1], point_y}) - $signed(OW'(rect.top));
    hit = rect.nonempty && !ox[OW-1] && !oy[OW-1] &&
          (ox < $signed(OW'(rect.width))) && (oy < $signed(OW'(rect.height)));
  end

  // stage valid bits
  assign valid_in = {valid_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (load[i]) begin
          valid_r[i] <= valid_in[i];
        end
      end
    end
  end

  // capture stage
  always_ff @(posedge clk) begin
    if (load[0]) begin
      inside_r[0] <= hit;
      acc_x_r[0]  <= hit ? lpm_pkg::PROD_W'(ox[lpm_pkg::CW-1:0]) : '0;
      acc_y_r[0]  <= hit ? lpm_pkg::PROD_W'(oy[lpm_pkg::CW-1:0]) : '0;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (load[1]) begin
      inside_r[1] <= inside_r[0];
      acc_x_r[1]  <= lpm_pkg::PROD_W'(acc_x_r[0][lpm_pkg::CW-1:0]) *
                     lpm_pkg::PROD_W'(design_w);
      acc_y_r[1]  <= lpm_pkg::PROD_W'(acc_y_r[0][lpm_pkg::CW-1:0]) *
                     lpm_pkg::PROD_W'(design_h);
    end
  end

  // divide stages
  for (genvar s = 2; s < NS; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (load[s]) begin
        inside_r[s] <= inside_r[s-1];
        acc_x_r[s]  <= lpm_pkg::lpm_div_step(acc_x_r[s-1], rect.width);
        acc_y_r[s]  <= lpm_pkg::lpm_div_step(acc_y_r[s-1], rect.height);
      end
    end
  end

  assign in_ready   = load[0];
  assign out_valid  = valid_r[NS-1];
  assign inside_res = inside_r[NS-1];
  assign design_x   = inside_r[NS-1] ? acc_x_r[NS-1][lpm_pkg::CW-1:0] : '0;
  assign design_y   = inside_r[NS-1] ? acc_y_r[NS-1][lpm_pkg::CW-1:0] : '0;

endmodule

### hdl/letterbox_point_mapper_top.sv
// ----------------------------------------------------------------------------
// letterbox_point_mapper_top
// Fits the design image into the target area with aspect kept and maps
// target points inside the rectangle back to design coordinates.
// ----------------------------------------------------------------------------
// channel  | dir | handshake          | payload
// in_      | in  | in_tvalid/tready   | tdata: point_x, point_y
// out_     | out | out_tvalid/tready  | tdata: design_x..rect_height, tuser: inside
// cfg_     | in  | APB, pready high   | 5 registers at 4*index
//
// One point per cycle unless out_ stalls or the rectangle is being recomputed;
// the stages are capture, multiply and 14 divide steps. After reset and after
// any register write a serial divider recomputes the rectangle; in_tready
// stays low meanwhile. Reset is synchronous; a stall at out_ holds the
// pipeline and only closes bubbles, so no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module letterbox_point_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // point_x[15:0], point_y[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,    // design_x, design_y, rect_left, rect_top,
                                    // rect_width, rect_height (14 bits each)
  output logic        out_tuser,    // inside_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [lpm_pkg::CW-1:0] design_w_r, design_h_r, target_w_r, target_h_r;
  logic [lpm_pkg::PW-1:0] scale_r;
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;
  logic                   rect_ready;
  logic                   pipe_ready;
  lpm_pkg::lpm_rect_t     rect;
  logic [lpm_pkg::CW-1:0] design_x, design_y;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      design_w_r <= lpm_pkg::RST_DESIGN_W;
      design_h_r <= lpm_pkg::RST_DESIGN_H;
      target_w_r <= lpm_pkg::RST_TARGET_W;
      target_h_r <= lpm_pkg::RST_TARGET_H;
      scale_r    <= lpm_pkg::RST_SCALE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lpm_pkg::REG_DESIGN_W: design_w_r <= cfg_pwdata[lpm_pkg::CW-1:0];
        lpm_pkg::REG_DESIGN_H: design_h_r <= cfg_pwdata[lpm_pkg::CW-1:0];
        lpm_pkg::REG_TARGET_W: target_w_r <= cfg_pwdata[lpm_pkg::CW-1:0];
        lpm_pkg::REG_TARGET_H: target_h_r <= cfg_pwdata[lpm_pkg::CW-1:0];
        lpm_pkg::REG_SCALE:    scale_r    <= cfg_pwdata[lpm_pkg::PW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_idx)
      lpm_pkg::REG_DESIGN_W: cfg_prdata = 32'(design_w_r);
      lpm_pkg::REG_DESIGN_H: cfg_prdata = 32'(design_h_r);
      lpm_pkg::REG_TARGET_W: cfg_prdata = 32'(target_w_r);
      lpm_pkg::REG_TARGET_H: cfg_prdata = 32'(target_h_r);
      lpm_pkg::REG_SCALE:    cfg_prdata = 32'(scale_r);
      default:               cfg_prdata = '0;
    endcase
  end

  lpm_rect_calc u_rect (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .design_w   (design_w_r),
    .design_h   (design_h_r),
    .target_w   (target_w_r),
    .target_h   (target_h_r),
    .scale      (scale_r),
    .rect_ready (rect_ready),
    .rect       (rect)
  );

  lpm_point_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid && rect_ready),
    .in_ready   (pipe_ready),
    .point_x    (in_tdata[15:0]),
    .point_y    (in_tdata[31:16]),
    .rect       (rect),
    .design_w   (design_w_r),
    .design_h   (design_h_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .inside_res (out_tuser),
    .design_x   (design_x),
    .design_y   (design_y)
  );

  assign in_tready = pipe_ready && rect_ready;
  assign out_tdata = {4'b0, rect.height, rect.width, rect.top, rect.left,
                      design_y, design_x};

endmodule

### sim/letterbox_point_mapper_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// letterbox_point_mapper_checker
// Watches the point and result streams and the register port, predicts the
// letterbox rectangle and the mapped design point for every accepted point,
// and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module letterbox_point_mapper_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending_count,
  output int          hit_count
);

  typedef struct packed {
    logic                   hit;
    logic [lpm_pkg::CW-1:0] dx;
    logic [lpm_pkg::CW-1:0] dy;
    logic [lpm_pkg::CW-1:0] left;
    logic [lpm_pkg::CW-1:0] top;
    logic [lpm_pkg::CW-1:0] w;
    logic [lpm_pkg::CW-1:0] h;
  } mapping_t;

  logic [lpm_pkg::CW-1:0] design_w, design_h, target_w, target_h;
  logic [lpm_pkg::PW-1:0] scale_pct;
  mapping_t               mapping_q[$];

  // rectangle and inverse mapping of one point
  function automatic mapping_t map_point(logic signed [15:0] px, logic signed [15:0] py);
    mapping_t m;
    longint dw, dh, tw, th, p, rw, rh, lf, tp, x, y;
    m  = '0;
    dw = design_w; dh = design_h; tw = target_w; th = target_h; p = scale_pct;
    x  = px; y = py;
    if (tw == 0 || th == 0 || dw == 0 || dh == 0) return m;
    if (p < lpm_pkg::PCT_MIN) p = lpm_pkg::PCT_MIN;
    if (p > lpm_pkg::PCT_FULL) p = lpm_pkg::PCT_FULL;
    // round half up: (2n + d) / 2d
    if (tw * dh <= th * dw) begin
      rw = (2 * tw * p + 100) / 200;
      rh = (2 * dh * tw * p + dw * 100) / (2 * dw * 100);
    end else begin
      rh = (2 * th * p + 100) / 200;
      rw = (2 * dw * th * p + dh * 100) / (2 * dh * 100);
    end
    if (rw < 1) rw = 1;
    if (rh < 1) rh = 1;
    if (rw > tw) rw = tw;
    if (rh > th) rh = th;
    lf = (tw - rw) / 2;
    tp = (th - rh) / 2;
    m.left = lf; m.top = tp; m.w = rw; m.h = rh;
    if (x >= lf && y >= tp && x < lf + rw && y < tp + rh) begin
      m.hit = 1'b1;
      m.dx = ((x - lf) * dw) / rw;
      m.dy = ((y - tp) * dh) / rh;
    end
    return m;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = mapping_q.size();

  always @(posedge clk) begin
    mapping_t exp_m;
    if (!rst_n) begin
      design_w <= lpm_pkg::RST_DESIGN_W;
      design_h <= lpm_pkg::RST_DESIGN_H;
      target_w <= lpm_pkg::RST_TARGET_W;
      target_h <= lpm_pkg::RST_TARGET_H;
      scale_pct <= lpm_pkg::RST_SCALE;
      fail_count = 0;
      hit_count = 0;
      mapping_q.delete();
    end else begin
      // register write transaction
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          lpm_pkg::REG_DESIGN_W: design_w <= cfg_pwdata[lpm_pkg::CW-1:0];
          lpm_pkg::REG_DESIGN_H: design_h <= cfg_pwdata[lpm_pkg::CW-1:0];
          lpm_pkg::REG_TARGET_W: target_w <= cfg_pwdata[lpm_pkg::CW-1:0];
          lpm_pkg::REG_TARGET_H: target_h <= cfg_pwdata[lpm_pkg::CW-1:0];
          lpm_pkg::REG_SCALE:    scale_pct <= cfg_pwdata[lpm_pkg::PW-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        mapping_q.push_back(map_point(in_tdata[15:0], in_tdata[31:16]));
      // result transaction
      if (out_tvalid && out_tready) begin
        if (mapping_q.size() == 0) begin
          $error("result transaction with no point outstanding");
          fail_count++;
        end else begin
          exp_m = mapping_q.pop_front();
          if (out_tuser) hit_count++;
          check_field("inside_res", exp_m.hit, out_tuser);
          check_field("design_x", exp_m.dx, out_tdata[13:0]);
          check_field("design_y", exp_m.dy, out_tdata[27:14]);
          check_field("rect_left", exp_m.left, out_tdata[41:28]);
          check_field("rect_top", exp_m.top, out_tdata[55:42]);
          check_field("rect_width", exp_m.w, out_tdata[69:56]);
          check_field("rect_height", exp_m.h, out_tdata[83:70]);
        end
      end
    end
  end

endmodule

### sim/letterbox_point_mapper_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// letterbox_point_mapper_top_tb
// Drives register settings and target points into the letterbox point mapper
// under varying stream back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module letterbox_point_mapper_top_tb;

  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 400000;
  // index with no register behind it
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending_count, hit_count;
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          points_sent = 0, settings_used = 0;
  longint      cycle = 0;

  letterbox_point_mapper_top i_dut (.*);

  letterbox_point_mapper_checker i_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  // setup and access phases, then the bus returns to idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every result is back and the pipeline is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(int dw, int dh, int tw, int th, int pct);
    drain();
    write_reg(lpm_pkg::REG_DESIGN_W, dw);
    write_reg(lpm_pkg::REG_DESIGN_H, dh);
    write_reg(lpm_pkg::REG_TARGET_W, tw);
    write_reg(lpm_pkg::REG_TARGET_H, th);
    write_reg(lpm_pkg::REG_SCALE, pct);
    settings_used++;
  endtask

  // in_tvalid stays high into the next call; idle cycles drop it
  task automatic send_point(logic [15:0] px, logic [15:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    points_sent++;
  endtask

  // mostly points in or just past the target area, some anywhere in 16 bits
  task automatic send_random_points(int count, int tw, int th);
    logic [15:0] px, py;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) begin
        px = $urandom_range(tw + 2);
        py = $urandom_range(th + 2);
        if ($urandom_range(19) == 0) px = -$urandom_range(3);
      end else begin
        px = $urandom; py = $urandom;
      end
      send_point(px, py);
    end
  endtask

  int tw, th;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: corners, edges and field extremes
    send_point(16'h0000, 16'h0000);
    send_point(16'd639, 16'd479);
    send_point(16'd640, 16'd479);
    send_point(16'd639, 16'd480);
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000);
    send_point(16'hFFFF, 16'h0001);
    send_point(16'd320, 16'd240);

    // pillarbox, tiny scale below the clamp
    apply_setting(640, 480, 1920, 480, 3);
    send_point(16'd960, 16'd240);
    send_point(16'd900, 16'd230);
    // letterbox, scale above full
    apply_setting(1920, 1080, 640, 640, 255);
    send_point(16'd0, 16'd140);
    send_point(16'd639, 16'd499);
    send_point(16'd10, 16'd100);
    // empty target, either axis
    apply_setting(640, 480, 0, 480, 100);
    send_point(16'd0, 16'd0);
    apply_setting(640, 480, 640, 0, 100);
    send_point(16'd0, 16'd0);
    // zero design size (out of range)
    apply_setting(0, 480, 640, 480, 100);
    send_point(16'd1, 16'd1);
    // maximum sizes, scale at 200 and at 10
    apply_setting(16383, 16383, 16383, 16383, 200);
    send_point(16'd16382, 16'd16382);
    send_point(16'd16383, 16'd0);
    apply_setting(16383, 1, 1, 16383, 10);
    send_point(16'd0, 16'd0);
    send_point(16'd0, 16'd8000);
    // write to an unused register index is ignored
    drain();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    send_point(16'd0, 16'd0);

    // random part in three pressure phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 34 : 0;
      for (int s = 0; s < 10; s++) begin
        tw = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(1, 2000);
        th = ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(1, 2000);
        if ($urandom_range(15) == 0) tw = 0;
        apply_setting($urandom_range(7) == 0 ? $urandom_range(1, 16383) : $urandom_range(1, 2000),
                      $urandom_range(7) == 0 ? $urandom_range(1, 16383) : $urandom_range(1, 2000),
                      tw, th, $urandom_range(255));
        send_random_points(31, tw, th);
      end
    end

    drain();
    $display("covered %0d points over %0d register settings, %0d hits inside",
             points_sent, settings_used, hit_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
